@@ rtl/lld_pkg.sv @@
// ============================================================================
// lld_pkg: shared definitions for the log-determinant block
// Sequencer states, fixed-point constants and the default matrix order.
// ============================================================================
package lld_pkg;

    // Default largest matrix order held in the store
    localparam int DEFAULT_MAX_ORDER = 16;

    // ln(2) in unsigned Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Saturation limits of a signed Q16.16 word
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Divider and log sequencing lengths
    localparam int DIV_STEPS  = 48;
    localparam int FRAC_BITS  = 16;

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_COL,
        ST_RD_ACC,
        ST_GET_ACC,
        ST_RD_X,
        ST_GET_X,
        ST_GET_Y,
        ST_MUL,
        ST_ACC,
        ST_WR,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SRCH,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_DV_START,
        ST_DV_RD,
        ST_DV_LD,
        ST_DV_IT,
        ST_DV_WR,
        ST_LG_START,
        ST_LG_RD,
        ST_LG_LD,
        ST_LG_NORM,
        ST_LG_SQ,
        ST_LG_RED,
        ST_LG_MUL,
        ST_LG_ACC,
        ST_FIN
    } state_t;

endpackage

@@ rtl/lu_log_determinant.sv @@
// ============================================================================
// lu_log_determinant: ln|det| of a Q16.16 matrix by Doolittle LU
// Loads an n by n matrix into a store, factors it in place with row exchange
// on a zero pivot, and returns ln|det|, the sign, the swap count and status.
// ============================================================================
// Loading: n*n elements, one per cycle while ready; the last starts the work.
// Factoring: a product term steps through RD_X, GET_X, GET_Y, MUL and ACC;
// L entries use the one-bit-a-cycle divider; a row exchange swaps every column.
// Log: normalise each diagonal entry, then square and reduce per fraction bit.
// All steps share the single store read port; not ready while working.
// Reset (rst_n, async low) returns to loading with order 16 and no result.
module lu_log_determinant #(
    parameter int MAX_ORDER = lld_pkg::DEFAULT_MAX_ORDER
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         matrix_size,
    input  logic               element_valid,
    output logic               element_ready,
    input  logic signed [31:0] element_value,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] log_abs_det,
    output logic               det_negative,
    output logic [3:0]         swap_count,
    output logic               status
);

    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;

    lld_pkg::state_t state_reg, state_next;

    logic [4:0]          size_reg;
    logic [CW-1:0]       lr_reg, lc_reg, i_reg, j_reg, k_reg, m_reg;
    logic signed [55:0]  acc_reg;
    logic signed [31:0]  x_reg, y_reg, piv_reg, tmp_reg;
    logic signed [63:0]  prod_reg;
    logic [47:0]         dvd_reg;
    logic [31:0]         rem_reg, dabs_reg;
    logic                qneg_reg;
    logic [5:0]          cnt_reg;
    logic [31:0]         w_reg;
    logic [4:0]          p_reg;
    logic [30:0]         mant_reg;
    logic [61:0]         sq_reg;
    logic [15:0]         frac_reg;
    logic [3:0]          bit_reg;
    logic signed [53:0]  lnp_reg;
    logic signed [39:0]  lacc_reg;
    logic                neg_reg, sing_reg;
    logic [3:0]          tally_reg;
    logic                out_valid_reg, out_neg_reg, out_status_reg;
    logic signed [31:0]  out_log_reg;
    logic [3:0]          out_swap_reg;

    logic signed [31:0]  mem [DEPTH];
    logic signed [31:0]  rd_data_reg;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                wr_en;
    logic signed [31:0]  wr_data;

    logic [CW-1:0]       n_cur, lim;
    logic                elem_acc, cfg_acc, load_last, out_free;
    logic signed [63:0]  rnd_term;
    logic [32:0]         div_sh, div_diff;
    logic                div_ge;
    logic signed [31:0]  q_sat;
    logic [31:0]         rd_abs, piv_abs;
    logic [31:0]         sq_top;
    logic signed [20:0]  lg_val;
    logic signed [53:0]  ln_term;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_ORDER) + AW'(c);
    endfunction

    function automatic logic signed [31:0] sat56(input logic signed [55:0] v);
        if (v > 56'(lld_pkg::Q_MAX)) return lld_pkg::Q_MAX;
        if (v < 56'(lld_pkg::Q_MIN)) return lld_pkg::Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        if (v > 40'(lld_pkg::Q_MAX)) return lld_pkg::Q_MAX;
        if (v < 40'(lld_pkg::Q_MIN)) return lld_pkg::Q_MIN;
        return v[31:0];
    endfunction

    // Clamp the order to 1..MAX_ORDER
    always_comb
    begin
        if (size_reg == 5'd0)
            n_cur = CW'(1);
        else if (32'(size_reg) > MAX_ORDER)
            n_cur = CW'(MAX_ORDER);
        else
            n_cur = CW'(size_reg);
    end

    // A size write takes priority over an element in the same cycle
    assign lim       = (i_reg < j_reg) ? i_reg : j_reg;
    assign cfg_ready     = (state_reg == lld_pkg::ST_LOAD);
    assign element_ready = (state_reg == lld_pkg::ST_LOAD) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign elem_acc  = element_valid && element_ready;
    assign load_last = (lr_reg == n_cur - CW'(1)) && (lc_reg == n_cur - CW'(1));
    assign out_free  = !out_valid_reg || result_ready;

    // Rounded Q16.16 product term
    assign rnd_term = (prod_reg + 64'sd32768) >>> 16;

    // Restoring divider step
    assign div_sh   = {rem_reg, dvd_reg[47]};
    assign div_diff = div_sh - {1'b0, dabs_reg};
    assign div_ge   = (div_sh >= {1'b0, dabs_reg});

    // Saturate the truncated quotient with its sign
    always_comb
    begin
        if (qneg_reg)
        begin
            if (dvd_reg > 48'h0000_8000_0000)
                q_sat = lld_pkg::Q_MIN;
            else
                q_sat = 32'(-dvd_reg[31:0]);
        end
        else
        begin
            if (dvd_reg > 48'h0000_7FFF_FFFF)
                q_sat = lld_pkg::Q_MAX;
            else
                q_sat = dvd_reg[31:0];
        end
    end

    assign rd_abs  = rd_data_reg[31] ? 32'(~rd_data_reg + 32'sd1) : rd_data_reg;
    assign piv_abs = piv_reg[31] ? 32'(~piv_reg + 32'sd1) : piv_reg;
    assign sq_top  = sq_reg[61:30];
    assign lg_val  = {~p_reg[4], p_reg[3:0], frac_reg};
    assign ln_term = (lnp_reg + 54'sd2147483648) >>> 32;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lld_pkg::ST_LOAD:     if (elem_acc && load_last) state_next = lld_pkg::ST_COL;
            lld_pkg::ST_COL:      state_next = lld_pkg::ST_RD_ACC;
            lld_pkg::ST_RD_ACC:   state_next = lld_pkg::ST_GET_ACC;
            lld_pkg::ST_GET_ACC:
                state_next = (lim == CW'(0)) ? lld_pkg::ST_WR : lld_pkg::ST_RD_X;
            lld_pkg::ST_RD_X:     state_next = lld_pkg::ST_GET_X;
            lld_pkg::ST_GET_X:    state_next = lld_pkg::ST_GET_Y;
            lld_pkg::ST_GET_Y:    state_next = lld_pkg::ST_MUL;
            lld_pkg::ST_MUL:      state_next = lld_pkg::ST_ACC;
            lld_pkg::ST_ACC:
                state_next = (m_reg + CW'(1) < lim) ? lld_pkg::ST_RD_X : lld_pkg::ST_WR;
            lld_pkg::ST_WR:
                state_next = (i_reg + CW'(1) < n_cur) ? lld_pkg::ST_RD_ACC
                                                      : lld_pkg::ST_PIV_RD;
            lld_pkg::ST_PIV_RD:   state_next = lld_pkg::ST_PIV_CHK;
            lld_pkg::ST_PIV_CHK:
                state_next = (rd_data_reg != 32'sd0) ? lld_pkg::ST_DV_START
                                                     : lld_pkg::ST_SRCH;
            lld_pkg::ST_SRCH:
                state_next = (k_reg < n_cur) ? lld_pkg::ST_SRCH_RD : lld_pkg::ST_FIN;
            lld_pkg::ST_SRCH_RD:  state_next = lld_pkg::ST_SRCH_CHK;
            lld_pkg::ST_SRCH_CHK:
                state_next = (rd_data_reg != 32'sd0) ? lld_pkg::ST_SW_RA : lld_pkg::ST_SRCH;
            lld_pkg::ST_SW_RA:    state_next = lld_pkg::ST_SW_RB;
            lld_pkg::ST_SW_RB:    state_next = lld_pkg::ST_SW_WA;
            lld_pkg::ST_SW_WA:    state_next = lld_pkg::ST_SW_WB;
            lld_pkg::ST_SW_WB:
                state_next = (m_reg + CW'(1) < n_cur) ? lld_pkg::ST_SW_RA
                                                      : lld_pkg::ST_DV_START;
            lld_pkg::ST_DV_START:
            begin
                if (i_reg < n_cur)
                    state_next = lld_pkg::ST_DV_RD;
                else if (j_reg + CW'(1) < n_cur)
                    state_next = lld_pkg::ST_COL;
                else
                    state_next = lld_pkg::ST_LG_START;
            end
            lld_pkg::ST_DV_RD:    state_next = lld_pkg::ST_DV_LD;
            lld_pkg::ST_DV_LD:    state_next = lld_pkg::ST_DV_IT;
            lld_pkg::ST_DV_IT:
                if (cnt_reg == 6'(lld_pkg::DIV_STEPS - 1)) state_next = lld_pkg::ST_DV_WR;
            lld_pkg::ST_DV_WR:    state_next = lld_pkg::ST_DV_START;
            lld_pkg::ST_LG_START:
                state_next = (i_reg < n_cur) ? lld_pkg::ST_LG_RD : lld_pkg::ST_FIN;
            lld_pkg::ST_LG_RD:    state_next = lld_pkg::ST_LG_LD;
            lld_pkg::ST_LG_LD:    state_next = lld_pkg::ST_LG_NORM;
            lld_pkg::ST_LG_NORM:  if (w_reg[31]) state_next = lld_pkg::ST_LG_SQ;
            lld_pkg::ST_LG_SQ:    state_next = lld_pkg::ST_LG_RED;
            lld_pkg::ST_LG_RED:
                state_next = (bit_reg == 4'd0) ? lld_pkg::ST_LG_MUL : lld_pkg::ST_LG_SQ;
            lld_pkg::ST_LG_MUL:   state_next = lld_pkg::ST_LG_ACC;
            lld_pkg::ST_LG_ACC:   state_next = lld_pkg::ST_LG_START;
            lld_pkg::ST_FIN:      if (out_free) state_next = lld_pkg::ST_LOAD;
            default:              state_next = lld_pkg::ST_LOAD;
        endcase
    end

    // Store port selection
    always_comb
    begin
        rd_addr = addr_of(i_reg, j_reg);
        wr_en   = 1'b0;
        wr_addr = addr_of(i_reg, j_reg);
        wr_data = q_sat;
        unique case (state_reg)
            lld_pkg::ST_LOAD:
            begin
                wr_en   = elem_acc;
                wr_addr = addr_of(lr_reg, lc_reg);
                wr_data = element_value;
            end
            lld_pkg::ST_RD_X:    rd_addr = addr_of(i_reg, m_reg);
            lld_pkg::ST_GET_X:   rd_addr = addr_of(m_reg, j_reg);
            lld_pkg::ST_PIV_RD:  rd_addr = addr_of(j_reg, j_reg);
            lld_pkg::ST_SRCH_RD: rd_addr = addr_of(k_reg, j_reg);
            lld_pkg::ST_SW_RA:   rd_addr = addr_of(j_reg, m_reg);
            lld_pkg::ST_SW_RB:   rd_addr = addr_of(k_reg, m_reg);
            lld_pkg::ST_LG_RD:   rd_addr = addr_of(i_reg, i_reg);
            lld_pkg::ST_WR:
            begin
                wr_en   = 1'b1;
                wr_data = sat56(acc_reg);
            end
            lld_pkg::ST_SW_WA:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(j_reg, m_reg);
                wr_data = rd_data_reg;
            end
            lld_pkg::ST_SW_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(k_reg, m_reg);
                wr_data = tmp_reg;
            end
            lld_pkg::ST_DV_WR:   wr_en = 1'b1;
            default:             wr_en = 1'b0;
        endcase
    end

    // Matrix store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lld_pkg::ST_LOAD;
            size_reg      <= 5'd16;
            lr_reg        <= '0;
            lc_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            tally_reg     <= '0;
            sing_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Raise the result on completion, drop it once taken
            if ((state_reg == lld_pkg::ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                lld_pkg::ST_LOAD:
                begin
                    if (cfg_acc)
                    begin
                        size_reg <= matrix_size;
                        lr_reg   <= '0;
                        lc_reg   <= '0;
                    end
                    else if (elem_acc)
                    begin
                        if (load_last)
                        begin
                            lr_reg    <= '0;
                            lc_reg    <= '0;
                            j_reg     <= '0;
                            tally_reg <= '0;
                            sing_reg  <= 1'b0;
                        end
                        else if (lc_reg == n_cur - CW'(1))
                        begin
                            lc_reg <= '0;
                            lr_reg <= lr_reg + CW'(1);
                        end
                        else
                            lc_reg <= lc_reg + CW'(1);
                    end
                end
                lld_pkg::ST_COL:     i_reg <= '0;
                lld_pkg::ST_GET_ACC: m_reg <= '0;
                lld_pkg::ST_ACC:     m_reg <= m_reg + CW'(1);
                lld_pkg::ST_WR:      i_reg <= i_reg + CW'(1);
                lld_pkg::ST_PIV_CHK:
                begin
                    i_reg <= j_reg + CW'(1);
                    k_reg <= j_reg + CW'(1);
                end
                lld_pkg::ST_SRCH:
                    if (!(k_reg < n_cur)) sing_reg <= 1'b1;
                lld_pkg::ST_SRCH_CHK:
                begin
                    if (rd_data_reg != 32'sd0)
                        m_reg <= '0;
                    else
                        k_reg <= k_reg + CW'(1);
                end
                lld_pkg::ST_SW_WB:
                begin
                    m_reg <= m_reg + CW'(1);
                    if (!(m_reg + CW'(1) < n_cur))
                        tally_reg <= tally_reg + 4'd1;
                end
                lld_pkg::ST_DV_START:
                begin
                    if (!(i_reg < n_cur))
                    begin
                        if (j_reg + CW'(1) < n_cur)
                            j_reg <= j_reg + CW'(1);
                        else
                        begin
                            i_reg   <= '0;
                            neg_reg <= 1'b0;
                        end
                    end
                end
                lld_pkg::ST_DV_LD:   cnt_reg <= '0;
                lld_pkg::ST_DV_IT:   cnt_reg <= cnt_reg + 6'd1;
                lld_pkg::ST_DV_WR:   i_reg <= i_reg + CW'(1);
                lld_pkg::ST_LG_LD:   neg_reg <= neg_reg ^ rd_data_reg[31];
                lld_pkg::ST_LG_NORM:
                    if (w_reg[31]) bit_reg <= 4'(lld_pkg::FRAC_BITS - 1);
                lld_pkg::ST_LG_RED:  bit_reg <= bit_reg - 4'd1;
                lld_pkg::ST_LG_ACC:  i_reg <= i_reg + CW'(1);
                default:
                begin
                end
            endcase
        end
    end

    // Datapath: accumulator, divider, log unit and result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lld_pkg::ST_GET_ACC: acc_reg <= 56'(rd_data_reg);
            lld_pkg::ST_GET_X:   x_reg <= rd_data_reg;
            lld_pkg::ST_GET_Y:   y_reg <= rd_data_reg;
            lld_pkg::ST_MUL:     prod_reg <= x_reg * y_reg;
            lld_pkg::ST_ACC:     acc_reg <= acc_reg - 56'(rnd_term);
            lld_pkg::ST_PIV_CHK: piv_reg <= rd_data_reg;
            lld_pkg::ST_SRCH_CHK:
                if (rd_data_reg != 32'sd0) piv_reg <= rd_data_reg;
            lld_pkg::ST_SW_RB:   tmp_reg <= rd_data_reg;
            lld_pkg::ST_DV_LD:
            begin
                dvd_reg  <= {rd_abs, 16'h0000};
                rem_reg  <= '0;
                dabs_reg <= piv_abs;
                qneg_reg <= rd_data_reg[31] ^ piv_reg[31];
            end
            lld_pkg::ST_DV_IT:
            begin
                rem_reg <= div_ge ? div_diff[31:0] : div_sh[31:0];
                dvd_reg <= {dvd_reg[46:0], div_ge};
            end
            lld_pkg::ST_DV_START:
                if (!(i_reg < n_cur) && !(j_reg + CW'(1) < n_cur)) lacc_reg <= '0;
            lld_pkg::ST_LG_LD:
            begin
                w_reg <= rd_abs;
                p_reg <= 5'd31;
            end
            lld_pkg::ST_LG_NORM:
            begin
                if (w_reg[31])
                begin
                    mant_reg <= w_reg[31:1];
                    frac_reg <= '0;
                end
                else
                begin
                    w_reg <= {w_reg[30:0], 1'b0};
                    p_reg <= p_reg - 5'd1;
                end
            end
            lld_pkg::ST_LG_SQ:   sq_reg <= 62'(mant_reg) * 62'(mant_reg);
            lld_pkg::ST_LG_RED:
            begin
                if (sq_top[31])
                begin
                    mant_reg          <= sq_top[31:1];
                    frac_reg[bit_reg] <= 1'b1;
                end
                else
                    mant_reg <= sq_top[30:0];
            end
            lld_pkg::ST_LG_MUL:  lnp_reg <= 54'(lg_val) * $signed({22'd0, lld_pkg::LN2_Q32});
            lld_pkg::ST_LG_ACC:  lacc_reg <= lacc_reg + 40'(ln_term);
            lld_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_log_reg    <= sing_reg ? lld_pkg::Q_MIN : sat40(lacc_reg);
                    out_neg_reg    <= sing_reg ? 1'b0 : (neg_reg ^ tally_reg[0]);
                    out_swap_reg   <= tally_reg;
                    out_status_reg <= sing_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign log_abs_det  = out_log_reg;
    assign det_negative = out_neg_reg;
    assign swap_count   = out_swap_reg;
    assign status       = out_status_reg;

    // Singular results carry the floor value and a positive sign
    a_singular_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (log_abs_det == lld_pkg::Q_MIN && !det_negative))
        else $error("singular result with wrong value or sign");

    // The mantissa stays normalised through squaring
    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lld_pkg::ST_LG_SQ) |-> mant_reg[30])
        else $error("log mantissa lost its leading one");

    // The last element starts factoring
    a_load_to_col: assert property (@(posedge clk) disable iff (!rst_n)
        (elem_acc && load_last) |=> (state_reg == lld_pkg::ST_COL))
        else $error("factoring did not start after the last element");

    // The divider never runs past its step count
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lld_pkg::ST_DV_IT) |-> (cnt_reg < 6'(lld_pkg::DIV_STEPS)))
        else $error("divider step count overrun");

endmodule

@@ dv/tb_lu_log_determinant.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lu_log_determinant: self-checking bench for the LU log-determinant block
// Loads matrices of many orders and contents, predicts ln|det|, sign, swap
// count and status in fixed point, and checks every result transaction.
// ----------------------------------------------------------------------------
module tb_lu_log_determinant;

    localparam int ORDER_MAX      = 16;
    localparam int TARGET_ELEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 1500;
    localparam logic signed [31:0] NEG_FULL = 32'sh8000_0000;
    localparam logic signed [31:0] POS_FULL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE_Q    = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] log_mag;
        logic               negative;
        logic [3:0]         swaps;
        logic               singular;
    } det_result_t;

    typedef enum logic [1:0] { ROW_SIZE, ROW_ELEM, ROW_ELEM_TYPED } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] data;
        det_result_t want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [4:0]         matrix_size = '0;
    logic               element_valid = 1'b0;
    logic               element_ready;
    logic signed [31:0] element_value = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic signed [31:0] log_abs_det;
    logic               det_negative;
    logic [3:0]         swap_count;
    logic               status;

    // Predictor state
    int          shadow_store [ORDER_MAX*ORDER_MAX];
    int unsigned fill_count = 0;
    logic [4:0]  order_reg = 5'd16;
    int unsigned swap_tally = 0;

    det_result_t pending_dets [$];
    int          mismatches = 0;
    int          elems_sent = 0;
    int          dets_seen = 0;
    int          singular_seen = 0;
    int          swapped_seen = 0;
    int          cfg_writes = 0;
    bit          no_idle = 1'b0;
    int          holds_wanted = 0;
    int          holds_served = 0;
    int          quiet_cycles = 0;

    lu_log_determinant dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .matrix_size   (matrix_size),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .element_value (element_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .log_abs_det   (log_abs_det),
        .det_negative  (det_negative),
        .swap_count    (swap_count),
        .status        (status)
    );

    always #5 clk = ~clk;

    // ---------------- fixed-point predictor ----------------
    function automatic int clamp32(longint x);
        if (x > longint'(POS_FULL)) return POS_FULL;
        if (x < longint'(NEG_FULL)) return NEG_FULL;
        return int'(x);
    endfunction

    function automatic longint round_mul(int a, int b);
        longint pr;
        pr = longint'(a) * longint'(b);
        return (pr + 64'sd32768) >>> 16;
    endfunction

    function automatic longint ln_fixed(int v);
        logic [31:0]       u;
        int                p;
        longint unsigned   m;
        longint            frac;
        longint            lg;
        u = (v < 0) ? (~v + 32'd1) : v;
        p = 31;
        while (p > 0 && !u[p]) p--;
        if (p <= 30) m = {32'b0, u} << (30 - p);
        else m = {32'b0, u} >> 1;
        frac = 0;
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= 64'd2147483648) begin
                m = m >> 1;
                frac = frac | (64'sd1 << b);
            end
        end
        lg = longint'((p - 16) * 65536) + frac;
        return (lg * 64'sd2977044472 + (64'sd1 << 31)) >>> 32;
    endfunction

    // Factor in place; returns 1 when a nonzero pivot was found in every column
    function automatic bit factor_shadow(int n);
        longint acc;
        longint piv;
        int     lim;
        int     tmp;
        bit     found;
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < n; i++) begin
                lim = (i < j) ? i : j;
                acc = shadow_store[i*ORDER_MAX + j];
                for (int m = 0; m < lim; m++)
                    acc -= round_mul(shadow_store[i*ORDER_MAX + m],
                                     shadow_store[m*ORDER_MAX + j]);
                shadow_store[i*ORDER_MAX + j] = clamp32(acc);
            end
            if (shadow_store[j*ORDER_MAX + j] == 0) begin
                found = 1'b0;
                for (int k = j + 1; k < n && !found; k++) begin
                    if (shadow_store[k*ORDER_MAX + j] != 0) begin
                        for (int m = 0; m < n; m++) begin
                            tmp = shadow_store[j*ORDER_MAX + m];
                            shadow_store[j*ORDER_MAX + m] = shadow_store[k*ORDER_MAX + m];
                            shadow_store[k*ORDER_MAX + m] = tmp;
                        end
                        swap_tally = (swap_tally + 1) & 16'hFFFF;
                        found = 1'b1;
                    end
                end
                if (!found) return 1'b0;
            end
            piv = shadow_store[j*ORDER_MAX + j];
            for (int i = j + 1; i < n; i++)
                shadow_store[i*ORDER_MAX + j] =
                    clamp32((longint'(shadow_store[i*ORDER_MAX + j]) * 65536) / piv);
        end
        return 1'b1;
    endfunction

    // Take one element; returns 1 with the determinant when the matrix is full
    function automatic bit absorb_element(int v, output det_result_t res);
        int     n;
        longint log_sum;
        bit     ok;
        bit     neg;
        int     d;
        n = (order_reg == 0) ? 1 : ((order_reg > ORDER_MAX) ? ORDER_MAX : order_reg);
        res = '0;
        if (fill_count >= n*n) fill_count = 0;
        shadow_store[(fill_count / n)*ORDER_MAX + (fill_count % n)] = v;
        fill_count++;
        if (fill_count < n*n) return 1'b0;
        fill_count = 0;
        swap_tally = 0;
        log_sum = 0;
        neg = 1'b0;
        ok = factor_shadow(n);
        if (ok) begin
            for (int i = 0; i < n; i++) begin
                d = shadow_store[i*ORDER_MAX + i];
                log_sum += ln_fixed(d);
                if (d < 0) neg = !neg;
            end
            if (swap_tally[0]) neg = !neg;
            res.log_mag = clamp32(log_sum);
        end else begin
            res.log_mag = NEG_FULL;
        end
        res.negative = neg;
        res.swaps    = swap_tally[3:0];
        res.singular = !ok;
        return 1'b1;
    endfunction

    // ---------------- drivers ----------------
    task automatic drain_then_settle();
        wait (pending_dets.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drop the element channel, wait for all results, then write the order
    task automatic write_order(logic [4:0] v);
        element_valid <= 1'b0;
        drain_then_settle();
        cfg_valid   <= 1'b1;
        matrix_size <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        order_reg  = v;
        fill_count = 0;
        cfg_writes++;
    endtask

    // Offer one element, hold until taken, then queue what it predicts
    task automatic send_element(logic [31:0] v, bit typed, det_result_t want);
        det_result_t got;
        if (!no_idle && $urandom_range(99) < 15) begin
            element_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        element_valid <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (!element_ready);
        elems_sent++;
        if (absorb_element(v, got))
            pending_dets.push_back(typed ? want : got);
    endtask

    function automatic logic [31:0] pick_element(int kind, bit on_diag);
        logic [31:0] v;
        case (kind)
            0: begin
                v = $urandom_range(131071) - 65536;
                if (on_diag) v = v + ($urandom_range(1) ? 1 : -1) * $urandom_range(4, 8) * 65536;
            end
            1: v = ($urandom_range(99) < 60) ? 32'd0
                   : (($urandom_range(8) - 4) * 65536 + $urandom_range(65535));
            3: v = $urandom;
            default: begin
                case ($urandom_range(5))
                    0: v = POS_FULL;
                    1: v = NEG_FULL;
                    2: v = 32'd0;
                    3: v = ONE_Q;
                    4: v = 32'hFFFF_FFFF;
                    default: v = 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_matrix(int n, int kind);
        logic [31:0] m [ORDER_MAX*ORDER_MAX];
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                m[r*n + c] = pick_element((kind == 2) ? 0 : kind, r == c);
        // Singular: repeat the first row in the last (or zero for order one)
        if (kind == 2) begin
            for (int c = 0; c < n; c++)
                m[(n-1)*n + c] = (n == 1) ? 32'd0 : m[c];
        end
        for (int i = 0; i < n*n; i++)
            send_element(m[i], 1'b0, '0);
    endtask

    // ---------------- result side ----------------
    initial begin
        @(posedge rst_n);
        forever begin
            if (holds_wanted > holds_served) begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end else begin
                result_ready <= no_idle || ($urandom_range(99) >= 15);
                @(posedge clk);
            end
        end
    end

    // Compare each result transaction against the oldest prediction
    always @(posedge clk) begin
        det_result_t want;
        if (result_valid && result_ready) begin
            dets_seen++;
            if (pending_dets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result log=%h neg=%b sw=%0d st=%b",
                             log_abs_det, det_negative, swap_count, status);
            end else begin
                want = pending_dets.pop_front();
                if (want.singular) singular_seen++;
                if (want.swaps != 0) swapped_seen++;
                if (log_abs_det !== want.log_mag || det_negative !== want.negative ||
                    swap_count !== want.swaps || status !== want.singular) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d want log=%h neg=%b sw=%0d st=%b",
                                  " got log=%h neg=%b sw=%0d st=%b"},
                                 dets_seen, want.log_mag, want.negative, want.swaps,
                                 want.singular, log_abs_det, det_negative, swap_count,
                                 status);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk) begin
        if ((element_valid && element_ready) || (cfg_valid && cfg_ready) ||
            (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_lu_log_determinant NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        stim_row_t table_rows [$];
        int        n;
        logic [4:0] sz;
        int        roll;

        // Directed rows: typed results only where obvious
        table_rows = '{
            '{ROW_SIZE,       32'd1,        '0},
            '{ROW_ELEM_TYPED, 32'd0,        '{NEG_FULL, 1'b0, 4'd0, 1'b1}},
            '{ROW_ELEM_TYPED, ONE_Q,        '{32'sd0, 1'b0, 4'd0, 1'b0}},
            '{ROW_ELEM_TYPED, -ONE_Q,       '{32'sd0, 1'b1, 4'd0, 1'b0}},
            '{ROW_ELEM,       POS_FULL,     '0},
            '{ROW_ELEM,       NEG_FULL,     '0},
            '{ROW_SIZE,       32'd2,        '0},
            '{ROW_ELEM,       32'd0,        '0},
            '{ROW_ELEM,       ONE_Q,        '0},
            '{ROW_ELEM,       ONE_Q,        '0},
            '{ROW_ELEM_TYPED, 32'd0,        '{32'sd0, 1'b1, 4'd1, 1'b0}},
            '{ROW_ELEM,       32'd0,        '0},
            '{ROW_ELEM,       32'd0,        '0},
            '{ROW_ELEM,       32'd0,        '0},
            '{ROW_ELEM_TYPED, 32'd0,        '{NEG_FULL, 1'b0, 4'd0, 1'b1}},
            '{ROW_SIZE,       32'd2,        '0},
            '{ROW_ELEM,       32'd5,        '0},
            '{ROW_ELEM,       32'd6,        '0},
            '{ROW_ELEM,       32'd7,        '0},
            // Rewrite mid-load: the three elements above are dropped
            '{ROW_SIZE,       32'd2,        '0},
            '{ROW_ELEM,       32'h0002_0000, '0},
            '{ROW_ELEM,       ONE_Q,        '0},
            '{ROW_ELEM,       32'h0003_0000, '0},
            '{ROW_ELEM,       32'h0004_0000, '0},
            // Order zero behaves as order one
            '{ROW_SIZE,       32'd0,        '0},
            '{ROW_ELEM,       32'h0002_8000, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i]) begin
            if (table_rows[i].kind == ROW_SIZE)
                write_order(table_rows[i].data[4:0]);
            else
                send_element(table_rows[i].data, table_rows[i].kind == ROW_ELEM_TYPED,
                             table_rows[i].want);
        end

        // Order above the store's size saturates to the largest order
        write_order(5'd31);
        send_matrix(ORDER_MAX, 1);

        // Random phases, mostly small orders
        while (elems_sent < TARGET_ELEMS) begin
            no_idle = (elems_sent > 500 && elems_sent < 750);
            if (elems_sent > 900 && holds_wanted == 0) begin
                // Hold the receiver off while order-one matrices keep coming
                write_order(5'd1);
                holds_wanted++;
                repeat (40) send_element(pick_element(0, 1'b1), 1'b0, '0);
                continue;
            end
            roll = $urandom_range(99);
            if (roll < 60)      sz = 5'($urandom_range(1, 4));
            else if (roll < 85) sz = 5'($urandom_range(5, 8));
            else if (roll < 96) sz = 5'($urandom_range(9, 15));
            else                sz = 5'($urandom_range(16, 31));
            write_order(sz);
            n = (sz > ORDER_MAX) ? ORDER_MAX : sz;
            repeat ((n > 8) ? 1 : $urandom_range(1, 5)) begin
                roll = $urandom_range(99);
                send_matrix(n, (roll < 40) ? 0 : (roll < 65) ? 1 : (roll < 78) ? 2 :
                               (roll < 92) ? 3 : 4);
            end
            // Now and then break a load off part way and restart it
            if (n > 1 && $urandom_range(9) == 0) begin
                repeat ($urandom_range(1, n*n - 1))
                    send_element($urandom, 1'b0, '0);
                write_order(sz);
                send_matrix(n, 0);
            end
        end

        element_valid <= 1'b0;
        wait (pending_dets.size() == 0);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("Covered %0d elements, %0d order writes, %0d determinants",
                 elems_sent, cfg_writes, dets_seen);
        $display("  of which %0d singular and %0d with row exchanges; %0d mismatches",
                 singular_seen, swapped_seen, mismatches);
        if (mismatches == 0)
            $display("tb_lu_log_determinant OK");
        else
            $display("tb_lu_log_determinant NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lld_pkg.sv
rtl/lu_log_determinant.sv
dv/tb_lu_log_determinant.sv
